// File: src/ssp_pkg.sv
package ssp_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int MAX_CH       = 3;
    localparam int WIDTH_W      = 16;
    localparam int CFG_ADDR_W   = 2;
    localparam int PEND_W       = 2;

    localparam int FIFO_DEPTH   = 3;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TOP    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_BASE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_INITIAL = 2'd2;

    // reset values
    localparam logic [WIDTH_W-1:0] PERIOD_TOP_RST    = 16'd40000;
    localparam logic [WIDTH_W-1:0] PULSE_BASE_RST    = 16'd2000;
    localparam logic [WIDTH_W-1:0] PULSE_INITIAL_RST = 16'd3000;

    // armed channel codes
    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_A    = 2'd1;
    localparam logic [PEND_W-1:0] PEND_B    = 2'd2;
    localparam logic [PEND_W-1:0] PEND_C    = 2'd3;

    // command characters
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_Z = 8'h7a;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_X     = 8'h58;
    localparam logic [7:0] CHR_Y     = 8'h59;
    localparam logic [7:0] CHR_Z     = 8'h5a;

    localparam logic [4:0] ROT_SHIFT    = 5'd3;
    localparam logic [4:0] ALPHA_LEN    = 5'd26;
    localparam logic [7:0] DIGIT_SCALE  = 8'd200;
    localparam logic [WIDTH_W:0] WIDTH_MAX = 17'h0ffff;

    typedef logic [WIDTH_W-1:0]              t_width;
    typedef logic [MAX_CH-1:0][WIDTH_W-1:0]  t_widths;

    typedef struct packed {
        logic       fire;
        logic       is_tick;
        logic [7:0] rx_byte;
    } t_step;

    typedef struct packed {
        logic   load;
        t_width value;
    } t_preset;

    typedef struct packed {
        logic [MAX_CH-1:0] pwm;
        logic              tx_valid;
        logic [7:0]        tx_byte;
    } t_result;

endpackage

// File: src/ssp_cmd.sv
module ssp_cmd (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssp_pkg::t_step   i_step,
    input  ssp_pkg::t_width  i_pulse_base,
    input  ssp_pkg::t_preset i_preset,
    output ssp_pkg::t_widths o_cmd_width,
    output logic             o_tx_valid,
    output logic [7:0]       o_tx_byte
);

    logic [ssp_pkg::PEND_W-1:0] r_pending;
    logic [ssp_pkg::PEND_W-1:0] n_pending;
    ssp_pkg::t_widths           r_cmd;
    ssp_pkg::t_widths           n_cmd;

    logic [ssp_pkg::WIDTH_W:0]  data_sum;
    logic [ssp_pkg::WIDTH_W:0]  digit_sum;
    logic [11:0]                digit_prod;
    ssp_pkg::t_width            data_width;
    ssp_pkg::t_width            digit_width;
    logic [4:0]                 rot_idx;
    logic [4:0]                 rot_sum;
    logic [4:0]                 rot_wrap;
    logic                       is_lower;
    logic                       is_digit;

    // saturating width sums
    assign data_sum    = {1'b0, i_pulse_base} + {6'd0, i_step.rx_byte, 3'd0};
    assign digit_prod  = {8'd0, i_step.rx_byte[3:0]} * {4'd0, ssp_pkg::DIGIT_SCALE};
    assign digit_sum   = {1'b0, i_pulse_base} + {5'd0, digit_prod};
    assign data_width  = (data_sum > ssp_pkg::WIDTH_MAX) ? 16'hffff : data_sum[15:0];
    assign digit_width = (digit_sum > ssp_pkg::WIDTH_MAX) ? 16'hffff : digit_sum[15:0];

    // rotate by three, wrapping past z
    assign rot_idx  = 5'(i_step.rx_byte - ssp_pkg::CHR_LOW_A);
    assign rot_sum  = rot_idx + ssp_pkg::ROT_SHIFT;
    assign rot_wrap = (rot_sum >= ssp_pkg::ALPHA_LEN) ? rot_sum - ssp_pkg::ALPHA_LEN : rot_sum;

    assign is_lower = (i_step.rx_byte >= ssp_pkg::CHR_LOW_A) &&
                      (i_step.rx_byte <= ssp_pkg::CHR_LOW_Z);
    assign is_digit = (i_step.rx_byte >= ssp_pkg::CHR_ZERO) &&
                      (i_step.rx_byte <= ssp_pkg::CHR_NINE);

    always_comb begin
        n_pending  = r_pending;
        n_cmd      = r_cmd;
        o_tx_valid = 1'b0;
        o_tx_byte  = 8'd0;
        if (i_step.fire && !i_step.is_tick) begin
            if (r_pending != ssp_pkg::PEND_NONE) begin
                for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
                    if (i < ssp_pkg::NUM_CHANNELS && r_pending == ssp_pkg::PEND_W'(i + 1)) begin
                        n_cmd[i] = data_width;
                    end
                end
                n_pending = ssp_pkg::PEND_NONE;
            end else if (is_lower) begin
                o_tx_valid = 1'b1;
                o_tx_byte  = ssp_pkg::CHR_LOW_A + {3'd0, rot_wrap};
            end else if (is_digit) begin
                n_cmd[0] = digit_width;
            end else if (i_step.rx_byte == ssp_pkg::CHR_X) begin
                n_pending = ssp_pkg::PEND_A;
            end else if (i_step.rx_byte == ssp_pkg::CHR_Y) begin
                n_pending = ssp_pkg::PEND_B;
            end else if (i_step.rx_byte == ssp_pkg::CHR_Z) begin
                n_pending = ssp_pkg::PEND_C;
            end
        end
        if (i_preset.load) begin
            for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
                n_cmd[i] = i_preset.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= ssp_pkg::PEND_NONE;
            for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
                r_cmd[i] <= ssp_pkg::PULSE_INITIAL_RST;
            end
        end else begin
            r_pending <= n_pending;
            r_cmd     <= n_cmd;
        end
    end

    assign o_cmd_width = r_cmd;

endmodule

// File: src/ssp_pwm.sv
module ssp_pwm (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  ssp_pkg::t_width             i_period_top,
    input  ssp_pkg::t_widths            i_cmd_width,
    input  ssp_pkg::t_preset            i_preset,
    output logic [ssp_pkg::MAX_CH-1:0]  o_pwm
);

    ssp_pkg::t_width  r_count;
    ssp_pkg::t_width  n_count;
    ssp_pkg::t_widths r_active;
    ssp_pkg::t_widths n_active;
    logic             wrap;

    // wrap at or above top, also when top was lowered under the count
    assign wrap = i_tick && (r_count >= i_period_top);

    always_comb begin
        n_count  = r_count;
        n_active = r_active;
        if (i_tick) begin
            n_count = wrap ? '0 : r_count + 16'd1;
        end
        if (wrap) begin
            n_active = i_cmd_width;
        end
        if (i_preset.load) begin
            for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
                n_active[i] = i_preset.value;
            end
        end
        for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
            o_pwm[i] = (i < ssp_pkg::NUM_CHANNELS) && (n_count < n_active[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int i = 0; i < ssp_pkg::MAX_CH; i++) begin
                r_active[i] <= ssp_pkg::PULSE_INITIAL_RST;
            end
        end else begin
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

endmodule

// File: src/ssp_out_fifo.sv
module ssp_out_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  ssp_pkg::t_result               i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output ssp_pkg::t_result               o_data,
    output logic [ssp_pkg::FIFO_CNT_W-1:0] o_count
);

    ssp_pkg::t_result                r_mem [ssp_pkg::FIFO_DEPTH];
    logic [ssp_pkg::FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [ssp_pkg::FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [ssp_pkg::FIFO_CNT_W-1:0]  r_count;
    logic                            do_pop;

    localparam logic [ssp_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        ssp_pkg::FIFO_PTR_W'(ssp_pkg::FIFO_DEPTH - 1);

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + ssp_pkg::FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + ssp_pkg::FIFO_PTR_W'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + ssp_pkg::FIFO_CNT_W'(1);
                2'b01:   r_count <= r_count - ssp_pkg::FIFO_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: src/serial_servo_pwm_controller_core.sv
// three-channel servo pwm controller with a byte command interpreter. each input item
// is a received byte or one timer tick, and every item yields exactly one result item
// carrying the three pwm levels after that step plus an optional echoed byte. items
// are taken one per clock with no gaps while o_ready is high: an item is captured in
// an input register, the next cycle it updates the command and pwm state and its
// result is written into a three-entry output queue, so a result passes the input
// register and the queue before it can be taken. the input side stays ready while
// fewer than three items are in flight, which keeps full rate as long as the consumer
// takes one result per cycle and lets two results wait while new items still enter.
// configuration writes are single-cycle: index 0 is period_top, 1 pulse_base, 2
// pulse_initial (which presets every buffered and active width at once); other
// indexes are dropped. write configuration only while idle.
module serial_servo_pwm_controller_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic [7:0]                     i_rx_byte,
    // result item channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_pwm_a,
    output logic                           o_pwm_b,
    output logic                           o_pwm_c,
    output logic                           o_tx_valid,
    output logic [7:0]                     o_tx_byte,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [ssp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ssp_pkg::WIDTH_W-1:0]    i_cfg_wdata
);

    // configuration registers
    ssp_pkg::t_width r_period_top;
    ssp_pkg::t_width r_pulse_base;

    // input register stage
    logic            r_in_valid;
    logic            r_in_tick;
    logic [7:0]      r_in_byte;

    logic                            in_accept;
    logic [ssp_pkg::FIFO_CNT_W:0]    in_flight;
    logic [ssp_pkg::FIFO_CNT_W-1:0]  fifo_count;
    ssp_pkg::t_step                  step;
    ssp_pkg::t_preset                preset;
    ssp_pkg::t_widths                cmd_width;
    logic [ssp_pkg::MAX_CH-1:0]      pwm;
    logic                            tx_valid;
    logic [7:0]                      tx_byte;
    ssp_pkg::t_result                result;
    ssp_pkg::t_result                out_data;

    // ready while the queue can absorb everything already in flight plus one more
    assign in_flight = {1'b0, fifo_count} + {{ssp_pkg::FIFO_CNT_W{1'b0}}, r_in_valid};
    assign o_ready   = in_flight < (ssp_pkg::FIFO_CNT_W + 1)'(ssp_pkg::FIFO_DEPTH);
    assign in_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_period_top <= ssp_pkg::PERIOD_TOP_RST;
            r_pulse_base <= ssp_pkg::PULSE_BASE_RST;
        end else begin
            r_in_valid <= in_accept;
            if (i_cfg_we && i_cfg_addr == ssp_pkg::REG_PERIOD_TOP) begin
                r_period_top <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == ssp_pkg::REG_PULSE_BASE) begin
                r_pulse_base <= i_cfg_wdata;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_tick <= i_req_type;
            r_in_byte <= i_rx_byte;
        end
    end

    assign step.fire    = r_in_valid;
    assign step.is_tick = r_in_tick;
    assign step.rx_byte = r_in_byte;

    // pulse_initial is never read back, it only presets the widths
    assign preset.load  = i_cfg_we && (i_cfg_addr == ssp_pkg::REG_PULSE_INITIAL);
    assign preset.value = i_cfg_wdata;

    ssp_cmd u_cmd (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_pulse_base (r_pulse_base),
        .i_preset     (preset),
        .o_cmd_width  (cmd_width),
        .o_tx_valid   (tx_valid),
        .o_tx_byte    (tx_byte)
    );

    ssp_pwm u_pwm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (r_in_valid && r_in_tick),
        .i_period_top (r_period_top),
        .i_cmd_width  (cmd_width),
        .i_preset     (preset),
        .o_pwm        (pwm)
    );

    assign result.pwm      = pwm;
    assign result.tx_valid = tx_valid;
    assign result.tx_byte  = tx_byte;

    // result queue decouples the consumer from the step logic
    ssp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_in_valid),
        .i_data  (result),
        .i_pop   (i_ready),
        .o_valid (o_valid),
        .o_data  (out_data),
        .o_count (fifo_count)
    );

    assign o_pwm_a    = out_data.pwm[0];
    assign o_pwm_b    = out_data.pwm[1];
    assign o_pwm_c    = out_data.pwm[2];
    assign o_tx_valid = out_data.tx_valid;
    assign o_tx_byte  = out_data.tx_byte;

    // a step never lands in a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> fifo_count != ssp_pkg::FIFO_CNT_W'(ssp_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // an accepted item always reaches the step stage next cycle
    a_accept_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_in_valid)
        else $error("accepted item lost before step");

    // echo is only produced for byte items and is zero otherwise
    a_echo_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_tick) |-> (!tx_valid && tx_byte == 8'd0))
        else $error("echo produced on tick");

    // echoed byte is a lowercase letter
    a_echo_lower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_tx_valid) |->
            (o_tx_byte >= ssp_pkg::CHR_LOW_A && o_tx_byte <= ssp_pkg::CHR_LOW_Z))
        else $error("echo outside lowercase range");

endmodule

// File: dv/testbench.sv
module testbench;
    import ssp_pkg::*;

    // unused register slot, writes there must leave every setting alone
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // receiver hold-off length, long enough to fill the result queue and stall input
    localparam int unsigned HOLD_CYCLES = 120;

    // one result item: the three servo levels and the echo byte
    typedef struct packed {
        logic       pwm_a;
        logic       pwm_b;
        logic       pwm_c;
        logic       tx_valid;
        logic [7:0] tx_byte;
    } levels_t;

    // tracks command and pwm state, and keeps the levels each accepted item must produce
    class servo_pwm_tracker;
        t_width            period_top;
        t_width            pulse_base;
        t_width            pulse_initial;
        logic [PEND_W-1:0] armed;
        t_width            commanded [MAX_CH];
        t_width            active [MAX_CH];
        t_width            period_count;
        levels_t           levels_due [$];
        int unsigned       mismatches;
        int unsigned       results_checked;
        int unsigned       echoes;
        int unsigned       reloads;

        function new();
            period_top      = PERIOD_TOP_RST;
            pulse_base      = PULSE_BASE_RST;
            pulse_initial   = PULSE_INITIAL_RST;
            armed           = PEND_NONE;
            period_count    = '0;
            mismatches      = 0;
            results_checked = 0;
            echoes          = 0;
            reloads         = 0;
            preset(PULSE_INITIAL_RST);
        endfunction

        // pulse_initial loads buffered and active widths at once
        function void preset(t_width w);
            foreach (commanded[i]) begin
                commanded[i] = w;
                active[i]    = w;
            end
        endfunction

        function t_width clamp_sum(int unsigned s);
            return (s > WIDTH_MAX) ? 16'hffff : t_width'(s);
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, t_width v);
            case (idx)
                REG_PERIOD_TOP: period_top = v;
                REG_PULSE_BASE: pulse_base = v;
                REG_PULSE_INITIAL: begin
                    pulse_initial = v;
                    preset(v);
                end
                default: ;
            endcase
        endfunction

        function void take_command(logic is_tick, logic [7:0] b);
            levels_t     lv;
            int unsigned ch;
            lv = '0;
            if (is_tick) begin
                // wrap at or above top, which also covers a top lowered under the count
                if (period_count >= period_top) period_count = '0;
                else period_count = period_count + 16'd1;
                if (period_count == 0) begin
                    reloads++;
                    foreach (active[i]) active[i] = commanded[i];
                end
            end else if (armed != PEND_NONE) begin
                // any byte after an arming command is data, even another command
                ch = 32'(armed) - 1;
                if (ch < NUM_CHANNELS)
                    commanded[ch] = clamp_sum(32'(pulse_base) + 32'(b) * 8);
                armed = PEND_NONE;
            end else if (b >= CHR_LOW_A && b <= CHR_LOW_Z) begin
                lv.tx_valid = 1'b1;
                lv.tx_byte  = 8'(32'(CHR_LOW_A) +
                                 (32'(b) - 32'(CHR_LOW_A) + 32'(ROT_SHIFT)) % 32'(ALPHA_LEN));
            end else if (b >= CHR_ZERO && b <= CHR_NINE) begin
                if (NUM_CHANNELS > 0)
                    commanded[0] = clamp_sum(32'(pulse_base) +
                                             (32'(b) - 32'(CHR_ZERO)) * 32'(DIGIT_SCALE));
            end else if (b == CHR_X) begin
                armed = PEND_A;
            end else if (b == CHR_Y) begin
                armed = PEND_B;
            end else if (b == CHR_Z) begin
                armed = PEND_C;
            end
            lv.pwm_a = (NUM_CHANNELS > 0) && (period_count < active[0]);
            lv.pwm_b = (NUM_CHANNELS > 1) && (period_count < active[1]);
            lv.pwm_c = (NUM_CHANNELS > 2) && (period_count < active[2]);
            levels_due.push_back(lv);
        endfunction

        function void check_levels(levels_t got);
            levels_t want;
            results_checked++;
            if (got.tx_valid === 1'b1) echoes++;
            if (levels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with nothing outstanding: a=%b b=%b c=%b tx=%b/%h",
                             results_checked, got.pwm_a, got.pwm_b, got.pwm_c,
                             got.tx_valid, got.tx_byte);
            end else begin
                want = levels_due.pop_front();
                if (got.pwm_a !== want.pwm_a || got.pwm_b !== want.pwm_b ||
                    got.pwm_c !== want.pwm_c || got.tx_valid !== want.tx_valid ||
                    got.tx_byte !== want.tx_byte) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d mismatch: expected a=%b b=%b c=%b tx=%b/%h,",
                                  " got a=%b b=%b c=%b tx=%b/%h"},
                                 results_checked, want.pwm_a, want.pwm_b, want.pwm_c,
                                 want.tx_valid, want.tx_byte, got.pwm_a, got.pwm_b,
                                 got.pwm_c, got.tx_valid, got.tx_byte);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_req_type;
    logic [7:0]            i_rx_byte;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_pwm_a;
    logic                  o_pwm_b;
    logic                  o_pwm_c;
    logic                  o_tx_valid;
    logic [7:0]            o_tx_byte;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    t_width                i_cfg_wdata;

    servo_pwm_tracker tracker;

    // pacing controls shared between the sender and the receiver process
    bit          tx_steady;
    bit          rx_steady;
    bit          hold_request;
    int unsigned n_ticks;
    int unsigned n_bytes;
    int unsigned n_settings;

    // opening items: bit 8 set means a timer tick
    logic [8:0] opening_items [26] = '{
        {1'b0, CHR_X}, {1'b0, 8'h00},                      // arm a, zero data
        {1'b0, CHR_Y}, {1'b1, 8'hff}, {1'b0, 8'hff},       // arm b, tick while armed, max data
        {1'b0, CHR_Z}, {1'b0, CHR_LOW_A},                  // arm c, a letter eaten as data
        {1'b0, CHR_LOW_A}, {1'b0, CHR_LOW_Z},              // letters at both ends
        {1'b0, CHR_LOW_Z - 8'd2}, {1'b0, CHR_LOW_Z - 8'd3}, // rotate wrap edge
        {1'b0, CHR_ZERO}, {1'b0, CHR_NINE},                // digits, nine saturates here
        {1'b0, 8'h00}, {1'b0, 8'hff}, {1'b0, 8'h41},       // ignored bytes
        {1'b0, CHR_LOW_A - 8'd1}, {1'b0, CHR_LOW_Z + 8'd1},
        {1'b0, CHR_ZERO - 8'd1}, {1'b0, CHR_NINE + 8'd1},
        {1'b0, CHR_X - 8'd1}, {1'b0, CHR_Z + 8'd1},
        {1'b0, CHR_X}, {1'b0, CHR_X},                      // arming byte taken as data
        {1'b1, 8'h00}, {1'b1, 8'h80}
    };

    serial_servo_pwm_controller_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pwm_a     (o_pwm_a),
        .o_pwm_b     (o_pwm_b),
        .o_pwm_c     (o_pwm_c),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // idle length: mostly short, sometimes medium, rarely long; never zero
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // both handshakes are sampled at the edge, before the design updates
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                tracker.take_command(i_req_type, i_rx_byte);
                if (i_req_type) n_ticks++;
                else n_bytes++;
            end
            if (o_valid && i_ready)
                tracker.check_levels('{o_pwm_a, o_pwm_b, o_pwm_c, o_tx_valid, o_tx_byte});
        end
    end

    // result receiver: random ready with occasional long hold-off when asked
    initial begin : receiver
        int unsigned run;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_steady) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 16);
                i_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                i_ready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
            end
        end
    end

    // offer one item and hold it until taken; valid stays up for a back-to-back item
    task automatic send_item(logic is_tick, logic [7:0] b);
        i_valid    <= 1'b1;
        i_req_type <= is_tick;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // send, then maybe leave a gap before the next item
    task automatic send_paced(logic is_tick, logic [7:0] b);
        send_item(is_tick, b);
        if (!tx_steady && $urandom_range(0, 99) >= 55) begin
            i_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    // stop offering and wait for every outstanding result, bounded
    task automatic drain();
        int unsigned guard;
        guard = 0;
        i_valid <= 1'b0;
        while (tracker.levels_due.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(logic [CFG_ADDR_W-1:0] idx, t_width v);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        tracker.write_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_all(t_width top, t_width base, t_width init);
        program_reg(REG_PERIOD_TOP, top);
        program_reg(REG_PULSE_BASE, base);
        program_reg(REG_PULSE_INITIAL, init);
        n_settings++;
    endtask

    // mostly well-formed commands with random content, ticks in between, some noise
    task automatic random_traffic(int unsigned n);
        int unsigned sent;
        int unsigned r;
        logic [7:0]  arm;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                send_paced(1'b1, 8'($urandom_range(0, 255)));
                sent++;
            end else if (r < 62) begin
                case ($urandom_range(0, 2))
                    0:       arm = CHR_X;
                    1:       arm = CHR_Y;
                    default: arm = CHR_Z;
                endcase
                send_paced(1'b0, arm);
                // a tick may land between the arming byte and its data
                if ($urandom_range(0, 5) == 0) send_paced(1'b1, 8'($urandom_range(0, 255)));
                // small data keeps widths near short periods
                if ($urandom_range(0, 3) == 0) send_paced(1'b0, 8'($urandom_range(0, 255)));
                else send_paced(1'b0, 8'($urandom_range(0, 40)));
                sent += 2;
            end else if (r < 74) begin
                send_paced(1'b0, 8'(32'(CHR_LOW_A) + $urandom_range(0, 25)));
                sent++;
            end else if (r < 86) begin
                send_paced(1'b0, 8'(32'(CHR_ZERO) + $urandom_range(0, 9)));
                sent++;
            end else begin
                send_paced(1'b0, 8'($urandom_range(0, 255)));
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned leftover;
        int unsigned failures;
        t_width      tops  [6] = '{16'd4, 16'd0, 16'd65535, 16'd1, 16'd300, 16'd40};
        t_width      bases [6] = '{16'd0, 16'd65535, 16'd0, 16'd100, 16'd37, 16'd0};
        t_width      inits [6] = '{16'd0, 16'd65535, 16'd1, 16'd2, 16'd150, 16'd0};

        tracker      = new();
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        n_ticks      = 0;
        n_bytes      = 0;
        n_settings   = 1;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req_type  <= 1'b0;
        i_rx_byte   <= 8'h00;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= REG_PERIOD_TOP;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a few items on reset settings first
        send_paced(1'b1, 8'h00);
        send_paced(1'b0, CHR_NINE);
        send_paced(1'b0, CHR_LOW_Z);
        drain();

        // short period with a huge base so data and digits saturate
        program_all(16'd3, 16'd65000, 16'd2);
        foreach (opening_items[k])
            send_paced(opening_items[k][8], opening_items[k][7:0]);
        drain();

        // last setting is random, lower base so widths stay near the period
        tops[5]  = t_width'($urandom_range(1, 600));
        bases[5] = t_width'($urandom_range(0, 300));
        inits[5] = t_width'($urandom_range(0, 65535));

        foreach (tops[p]) begin
            program_all(tops[p], bases[p], inits[p]);
            case (p)
                1: begin
                    // dropped write to the spare index, then no idling either side
                    program_reg(REG_UNUSED, t_width'($urandom_range(0, 65535)));
                    tx_steady = 1'b1;
                    rx_steady = 1'b1;
                    random_traffic(200);
                    tx_steady = 1'b0;
                    rx_steady = 1'b0;
                end
                2: begin
                    // receiver stalls long while the sender keeps pushing
                    random_traffic(60);
                    hold_request = 1'b1;
                    tx_steady    = 1'b1;
                    random_traffic(40);
                    tx_steady    = 1'b0;
                    random_traffic(100);
                end
                3: begin
                    // sender pauses mid-setting until every result is back
                    random_traffic(100);
                    drain();
                    random_traffic(100);
                end
                default: random_traffic(200);
            endcase
            drain();
        end

        drain();
        leftover = tracker.levels_due.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        failures = tracker.mismatches + leftover;

        $display("ran %0d items (%0d ticks, %0d bytes) across %0d register settings",
                 n_ticks + n_bytes, n_ticks, n_bytes, n_settings);
        $display("checked %0d results: %0d echoes, %0d period reloads, %0d mismatches",
                 tracker.results_checked, tracker.echoes, tracker.reloads,
                 tracker.mismatches);
        if (failures == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin : watchdog
        #1000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
